// ----- hdl/fbt_pkg.sv -----
// Shared types and constants of the flow bucket table.
package fbt_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_SEED   = 32'h0000_0001;
    localparam logic [31:0] COUNT_WRAP = 32'hFFFF_FFFE;
    localparam logic [2:0]  SLOT_FULL  = 3'd7;

    typedef enum logic [1:0] {
        OUTCOME_HIT    = 2'd0,
        OUTCOME_INSERT = 2'd1,
        OUTCOME_FULL   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } fbt_req_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [3:0]  bucket;
        logic [2:0]  slot;
        logic [31:0] pkt_count;
        logic [2:0]  occupancy;
        logic        ranking_valid;
        logic [20:0] ranking;
    } fbt_result_t;

endpackage

// ----- hdl/flow_bucket_table_with_ranking_core.sv -----
// Flow bucket table: key lookup, hit counting, insertion and heapsort ranking of a bucket.
//
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with result_valid, and the receiver cannot stall it. For a request
// the hash unit runs a CRC over the twelve key bytes and reduces it to a bucket, the
// bucket is handed over, its occupancy is read, each filled slot is scanned through the
// registered-read table memory and the outcome is decided; on a hit with two or more
// entries a heapsort of up to seven counts follows, with a left-child read, a right-child
// read and a write per sift level. result_valid rises as busy falls, so the next
// request may already be taken while the result is shown. After reset the block stays
// busy while it clears the bucket occupancy memory.
module flow_bucket_table_with_ranking_core import fbt_pkg::*; #(
    parameter int NUM_BUCKETS      = 16,
    parameter int SLOTS_PER_BUCKET = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  fbt_req_t    request,
    output logic        result_valid,
    output fbt_result_t result
);

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam logic [3:0] SPB4 = 4'(SLOTS_PER_BUCKET);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_OCC_RD, S_OCC_GET, S_SCAN_RD, S_SCAN_CHK,
        S_DECIDE, S_BUILD_RD, S_SIFT_L, S_SIFT_R, S_SIFT_W, S_SWAP1, S_SWAP2, S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]  idx;
        logic [31:0] cnt;
    } heap_ent_t;

    state_t          state_reg;
    fbt_req_t        req_reg;
    logic [BW-1:0]   clr_reg;
    logic [BW-1:0]   bkt_reg;
    logic [AW-1:0]   base_reg;
    logic [3:0]      occ_reg;
    logic [2:0]      scan_reg;
    logic            hit_found_reg;
    logic [2:0]      hit_slot_reg;
    logic [31:0]     hit_cnt_reg;
    heap_ent_t       heap_reg [8];
    heap_ent_t       cur_reg;
    heap_ent_t       best_reg;
    logic [2:0]      bestpos_reg;
    logic [2:0]      pos_reg;
    logic [2:0]      root_reg;
    logic [2:0]      end_reg;
    logic [3:0]      size_reg;
    logic            build_reg;
    logic [20:0]     ranking_reg;
    fbt_result_t     result_reg;
    logic            result_valid_reg;

    logic            hash_start;
    logic            hash_done;
    logic [BW-1:0]   hash_bucket;

    logic [95:0]     key_mem   [DEPTH];
    logic [31:0]     count_mem [DEPTH];
    logic [OW-1:0]   occ_mem   [NUM_BUCKETS];
    logic [95:0]     key_rd_reg;
    logic [31:0]     cnt_rd_reg;
    logic [OW-1:0]   occ_rd_reg;

    logic [2:0]      slot_sel;
    logic [AW-1:0]   ent_addr;
    logic            key_we;
    logic            cnt_we;
    logic [31:0]     cnt_wdata;
    logic [31:0]     new_cnt;
    logic [BW-1:0]   occ_addr;
    logic            occ_we;
    logic [OW-1:0]   occ_wdata;
    logic [95:0]     key_word;
    logic [4:0]      left_pos;
    logic [4:0]      right_pos;
    logic [2:0]      heap_raddr;
    heap_ent_t       heap_rd;
    logic [20:0]     rank_new;

    fbt_hash #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key_word),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign key_word   = {request.src_addr, request.dst_addr, request.src_port, request.dst_port};
    assign busy       = (state_reg != S_IDLE);
    assign hash_start = (state_reg == S_IDLE) && start;

    assign new_cnt = (hit_cnt_reg >= COUNT_WRAP) ? 32'd1 : hit_cnt_reg + 32'd1;

    // Slots fill from 0 upward and are never freed, so the first empty slot is the occupancy.
    assign slot_sel  = (state_reg == S_DECIDE)
                     ? (hit_found_reg ? hit_slot_reg : occ_reg[2:0]) : scan_reg;
    assign ent_addr  = base_reg + AW'(slot_sel);
    assign key_we    = (state_reg == S_DECIDE) && !hit_found_reg && (occ_reg < SPB4)
                     && (req_reg.src_addr != 32'd0);
    assign cnt_we    = (state_reg == S_DECIDE) && (hit_found_reg || key_we);
    assign cnt_wdata = hit_found_reg ? new_cnt : 32'd1;

    assign occ_addr  = (state_reg == S_CLEAR) ? clr_reg : bkt_reg;
    assign occ_we    = (state_reg == S_CLEAR) || key_we;
    assign occ_wdata = (state_reg == S_CLEAR) ? '0 : OW'(occ_reg + 4'd1);

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[ent_addr] <= {req_reg.src_addr, req_reg.dst_addr,
                                  req_reg.src_port, req_reg.dst_port};
        end
        if (cnt_we)
        begin
            count_mem[ent_addr] <= cnt_wdata;
        end
        key_rd_reg <= key_mem[ent_addr];
        cnt_rd_reg <= count_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_addr] <= occ_wdata;
        end
        occ_rd_reg <= occ_mem[occ_addr];
    end

    assign left_pos  = {1'b0, pos_reg, 1'b1};
    assign right_pos = {1'b0, pos_reg, 1'b0} + 5'd2;

    always_comb
    begin
        case (state_reg)
            S_SIFT_L:   heap_raddr = left_pos[2:0];
            S_SIFT_R:   heap_raddr = right_pos[2:0];
            S_SWAP1:    heap_raddr = end_reg;
            S_BUILD_RD: heap_raddr = root_reg;
            default:    heap_raddr = 3'd0;
        endcase
    end

    assign heap_rd = heap_reg[heap_raddr];

    always_comb
    begin
        rank_new = '0;
        for (int j = 0; j < 7; j++)
        begin
            if (j < SLOTS_PER_BUCKET)
            begin
                rank_new[3*j +: 3] = heap_reg[j].idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            req_reg          <= '0;
            clr_reg          <= '0;
            bkt_reg          <= '0;
            base_reg         <= '0;
            occ_reg          <= '0;
            scan_reg         <= '0;
            hit_found_reg    <= 1'b0;
            hit_slot_reg     <= '0;
            hit_cnt_reg      <= '0;
            for (int j = 0; j < 8; j++)
            begin
                heap_reg[j] <= '0;
            end
            cur_reg          <= '0;
            best_reg         <= '0;
            bestpos_reg      <= '0;
            pos_reg          <= '0;
            root_reg         <= '0;
            end_reg          <= '0;
            size_reg         <= '0;
            build_reg        <= 1'b0;
            ranking_reg      <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == BW'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= request;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        bkt_reg   <= hash_bucket;
                        base_reg  <= AW'(hash_bucket * SLOTS_PER_BUCKET);
                        state_reg <= S_OCC_RD;
                    end
                end
                S_OCC_RD:
                begin
                    state_reg <= S_OCC_GET;
                end
                S_OCC_GET:
                begin
                    occ_reg       <= 4'(occ_rd_reg);
                    scan_reg      <= '0;
                    hit_found_reg <= 1'b0;
                    for (int j = 0; j < 8; j++)
                    begin
                        heap_reg[j].idx <= 3'(j);
                    end
                    state_reg <= (occ_rd_reg == '0) ? S_DECIDE : S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    heap_reg[scan_reg].cnt <= cnt_rd_reg;
                    if (!hit_found_reg && key_rd_reg == {req_reg.src_addr, req_reg.dst_addr,
                                                          req_reg.src_port, req_reg.dst_port})
                    begin
                        hit_found_reg <= 1'b1;
                        hit_slot_reg  <= scan_reg;
                        hit_cnt_reg   <= cnt_rd_reg;
                    end
                    scan_reg <= scan_reg + 3'd1;
                    state_reg <= ((4'(scan_reg) + 4'd1) == occ_reg) ? S_DECIDE : S_SCAN_RD;
                end
                S_DECIDE:
                begin
                    result_reg.bucket        <= 4'(bkt_reg);
                    result_reg.ranking_valid <= 1'b0;
                    result_reg.ranking       <= ranking_reg;
                    result_reg.occupancy     <= 3'(occ_reg);
                    if (hit_found_reg)
                    begin
                        result_reg.outcome   <= OUTCOME_HIT;
                        result_reg.slot      <= hit_slot_reg;
                        result_reg.pkt_count <= new_cnt;
                        heap_reg[hit_slot_reg].cnt <= new_cnt;
                        if (occ_reg >= 4'd2)
                        begin
                            size_reg  <= occ_reg;
                            root_reg  <= 3'((occ_reg >> 1) - 4'd1);
                            build_reg <= 1'b1;
                            state_reg <= S_BUILD_RD;
                        end
                        else
                        begin
                            result_valid_reg <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (occ_reg < SPB4)
                        begin
                            result_reg.outcome   <= OUTCOME_INSERT;
                            result_reg.slot      <= occ_reg[2:0];
                            result_reg.pkt_count <= 32'd1;
                            if (key_we)
                            begin
                                result_reg.occupancy <= 3'(occ_reg + 4'd1);
                            end
                        end
                        else
                        begin
                            result_reg.outcome   <= OUTCOME_FULL;
                            result_reg.slot      <= SLOT_FULL;
                            result_reg.pkt_count <= 32'd0;
                        end
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                S_BUILD_RD:
                begin
                    cur_reg   <= heap_rd;
                    pos_reg   <= root_reg;
                    state_reg <= S_SIFT_L;
                end
                S_SIFT_L:
                begin
                    best_reg    <= cur_reg;
                    bestpos_reg <= pos_reg;
                    if (left_pos < 5'(size_reg) && heap_rd.cnt > cur_reg.cnt)
                    begin
                        best_reg    <= heap_rd;
                        bestpos_reg <= left_pos[2:0];
                    end
                    state_reg <= S_SIFT_R;
                end
                S_SIFT_R:
                begin
                    if (right_pos < 5'(size_reg) && heap_rd.cnt > best_reg.cnt)
                    begin
                        best_reg    <= heap_rd;
                        bestpos_reg <= right_pos[2:0];
                    end
                    state_reg <= S_SIFT_W;
                end
                S_SIFT_W:
                begin
                    if (bestpos_reg == pos_reg)
                    begin
                        heap_reg[pos_reg] <= cur_reg;
                        if (build_reg)
                        begin
                            if (root_reg == 3'd0)
                            begin
                                build_reg <= 1'b0;
                                end_reg   <= 3'(size_reg - 4'd1);
                                state_reg <= S_SWAP1;
                            end
                            else
                            begin
                                root_reg  <= root_reg - 3'd1;
                                state_reg <= S_BUILD_RD;
                            end
                        end
                        else if (end_reg == 3'd0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            end_reg   <= end_reg - 3'd1;
                            state_reg <= S_SWAP1;
                        end
                    end
                    else
                    begin
                        // The child moves up into the hole; the held entry keeps sinking.
                        heap_reg[pos_reg] <= best_reg;
                        pos_reg           <= bestpos_reg;
                        state_reg         <= S_SIFT_L;
                    end
                end
                S_SWAP1:
                begin
                    cur_reg   <= heap_rd;
                    state_reg <= S_SWAP2;
                end
                S_SWAP2:
                begin
                    heap_reg[end_reg] <= heap_rd;
                    pos_reg           <= 3'd0;
                    size_reg          <= 4'(end_reg);
                    state_reg         <= S_SIFT_L;
                end
                S_FINISH:
                begin
                    ranking_reg              <= rank_new;
                    result_reg.ranking       <= rank_new;
                    result_reg.ranking_valid <= 1'b1;
                    result_valid_reg         <= 1'b1;
                    state_reg                <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/fbt_hash.sv -----
// CRC of the key (CRC-32 poly, seed 1), one byte per cycle; bucket by reciprocal multiply.
module fbt_hash import fbt_pkg::*; #(
    parameter int NUM_BUCKETS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [95:0]                      key,
    output logic                             done,
    output logic [$clog2(NUM_BUCKETS)-1:0]   bucket
);

    localparam int BW = $clog2(NUM_BUCKETS);
    // Reciprocal rounded up, which gives the exact quotient for every 32-bit hash.
    localparam logic [63:0] RECIP    = ((64'd1 << (32 + BW)) + 64'(NUM_BUCKETS) - 64'd1)
                                       / 64'(NUM_BUCKETS);
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];
    localparam logic [16:0] NB_W     = 17'(NUM_BUCKETS);

    typedef enum logic [2:0] {H_IDLE, H_CRC, H_MUL_LO, H_MUL_HI, H_QUOT, H_REM} hstate_t;

    hstate_t        state_reg;
    logic [3:0]     cnt_reg;
    logic [31:0]    crc_reg;
    logic [95:0]    key_reg;
    logic [47:0]    prod_lo_reg;
    logic [48:0]    prod_hi_reg;
    logic [31:0]    quot_reg;
    logic [BW-1:0]  bucket_reg;
    logic           done_reg;
    logic [64:0]    prod_sum;
    logic [48:0]    quot_mul;
    logic [31:0]    rem_full;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    assign prod_sum = {17'd0, prod_lo_reg} + {prod_hi_reg, 16'd0};
    assign quot_mul = quot_reg * NB_W;
    assign rem_full = crc_reg - quot_mul[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= H_IDLE;
            cnt_reg     <= '0;
            crc_reg     <= '0;
            key_reg     <= '0;
            prod_lo_reg <= '0;
            prod_hi_reg <= '0;
            quot_reg    <= '0;
            bucket_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        key_reg   <= key;
                        crc_reg   <= CRC_SEED;
                        cnt_reg   <= '0;
                        state_reg <= H_CRC;
                    end
                end
                H_CRC:
                begin
                    crc_reg <= crc_byte(crc_reg, key_reg[95:88]);
                    key_reg <= {key_reg[87:0], 8'd0};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd11)
                    begin
                        state_reg <= H_MUL_LO;
                    end
                end
                H_MUL_LO:
                begin
                    prod_lo_reg <= crc_reg * RECIP_LO;
                    state_reg   <= H_MUL_HI;
                end
                H_MUL_HI:
                begin
                    prod_hi_reg <= crc_reg * RECIP_HI;
                    state_reg   <= H_QUOT;
                end
                H_QUOT:
                begin
                    quot_reg  <= 32'(prod_sum >> (32 + BW));
                    state_reg <= H_REM;
                end
                H_REM:
                begin
                    bucket_reg <= rem_full[BW-1:0];
                    done_reg   <= 1'b1;
                    state_reg  <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule
